// ===== sv/gwm_pkg.sv =====
package gwm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = $clog2(MAX_PATTERN);

    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUESTION  = 8'h3F;

    typedef enum logic [1:0] {
        FUNC_PATTERN = 2'd0,
        FUNC_SUBJECT = 2'd1,
        FUNC_END     = 2'd2,
        FUNC_CLEAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_ONE = 2'd1,
        KIND_RUN = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_token;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        t_token           tok;
    } t_wr_ctrl;

    typedef struct packed {
        logic             step;
        logic             rearm;
        logic [7:0]       ch;
        logic [LEN_W-1:0] len;
    } t_cell_ctrl;

    typedef struct packed {
        logic valid;
        logic matched;
        logic overflow;
    } t_result;

endpackage

// ===== sv/gwm_if.sv =====
interface gwm_in_if import gwm_pkg::*; ();
    logic       valid;
    logic       ready;
    t_func      func;
    logic [7:0] char_value;

    modport source(output valid, output func, output char_value, input ready);
    modport sink(input valid, input func, input char_value, output ready);
endinterface

interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source(output valid, output matched, output pattern_overflow, input ready);
    modport sink(input valid, input matched, input pattern_overflow, output ready);
endinterface

// ===== sv/gwm_cell.sv =====
module gwm_cell import gwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctrl       i_ctrl,
    input  t_wr_ctrl         i_wr,
    input  logic             i_close_in,
    input  logic             i_adv_in,
    output logic             o_close,
    output logic             o_adv,
    output logic             o_hit
);

    t_token r_tok;
    logic   r_act;
    logic   n_act;
    logic   w_valid;
    logic   w_closed;
    logic   w_is_run;
    logic   w_take;

    assign w_valid  = i_ctrl.len > LEN_W'(i_index);
    assign w_closed = r_act | i_close_in;
    assign w_is_run = (r_tok.kind == KIND_RUN);
    assign w_take   = (r_tok.kind == KIND_ONE) ||
                      ((r_tok.kind == KIND_LIT) && (r_tok.ch == i_ctrl.ch));

    // Adjacent run tokens never occur, so one level of closure is enough.
    assign o_close = r_act & w_valid & w_is_run;
    assign o_adv   = w_closed & w_valid & w_take;
    assign o_hit   = w_closed & (i_ctrl.len == LEN_W'(i_index));

    always_comb begin
        n_act = r_act;
        if (i_ctrl.rearm) begin
            n_act = (i_index == '0);
        end else if (i_ctrl.step) begin
            n_act = (w_closed & w_valid & w_is_run) | i_adv_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= (i_index == '0);
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.idx == i_index)) begin
            r_tok <= i_wr.tok;
        end
    end

endmodule

// ===== sv/gwm_loader.sv =====
module gwm_loader import gwm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_func            i_func,
    input  logic [7:0]       i_char,
    output logic [LEN_W-1:0] o_len,
    output logic             o_overflow,
    output t_wr_ctrl         o_wr
);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_esc;
    logic             n_esc;
    logic             r_star;
    logic             n_star;
    logic             r_ovf;
    logic             n_ovf;
    t_wr_ctrl         w_wr;

    always_comb begin
        logic   full;
        t_token tok;
        full    = (r_len >= LEN_W'(MAX_PATTERN));
        tok     = '{kind: KIND_LIT, ch: i_char};
        n_len   = r_len;
        n_esc   = r_esc;
        n_star  = r_star;
        n_ovf   = r_ovf;
        w_wr.en  = 1'b0;
        w_wr.idx = r_len[IDX_W-1:0];
        w_wr.tok = tok;
        if (i_accept) begin
            case (i_func)
                FUNC_PATTERN: begin
                    if (r_esc) begin
                        n_esc    = 1'b0;
                        n_star   = 1'b0;
                        w_wr.en  = (r_len != '0);
                        w_wr.idx = IDX_W'(r_len - LEN_W'(1));
                    end else if (i_char == CH_STAR) begin
                        w_wr.tok.kind = KIND_RUN;
                        if (!r_star) begin
                            if (full) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_wr.en = 1'b1;
                                n_len   = r_len + LEN_W'(1);
                                n_star  = 1'b1;
                            end
                        end
                    end else begin
                        n_star = 1'b0;
                        if (i_char == CH_QUESTION) begin
                            w_wr.tok.kind = KIND_ONE;
                        end
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            w_wr.en = 1'b1;
                            n_len   = r_len + LEN_W'(1);
                            if (i_char == CH_BACKSLASH) begin
                                n_esc = 1'b1;
                            end
                        end
                    end
                end
                FUNC_CLEAR: begin
                    n_len  = '0;
                    n_esc  = 1'b0;
                    n_star = 1'b0;
                    n_ovf  = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_esc  <= 1'b0;
            r_star <= 1'b0;
            r_ovf  <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_esc  <= n_esc;
            r_star <= n_star;
            r_ovf  <= n_ovf;
        end
    end

    assign o_len      = r_len;
    assign o_overflow = r_ovf;
    assign o_wr       = w_wr;

endmodule

// ===== sv/gwm_out_buf.sv =====
module gwm_out_buf import gwm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_result      i_res,
    output logic         o_can_accept,
    gwm_out_if.source    o_out
);

    logic r_out_valid;
    logic n_out_valid;
    logic r_out_matched;
    logic n_out_matched;
    logic r_out_ovf;
    logic n_out_ovf;
    logic r_skid_valid;
    logic n_skid_valid;
    logic r_skid_matched;
    logic n_skid_matched;
    logic r_skid_ovf;
    logic n_skid_ovf;
    logic w_take;

    assign w_take = r_out_valid & o_out.ready;

    always_comb begin
        n_out_valid    = r_out_valid;
        n_out_matched  = r_out_matched;
        n_out_ovf      = r_out_ovf;
        n_skid_valid   = r_skid_valid;
        n_skid_matched = r_skid_matched;
        n_skid_ovf     = r_skid_ovf;
        if (i_res.valid) begin
            if (r_out_valid && !o_out.ready) begin
                n_skid_valid   = 1'b1;
                n_skid_matched = i_res.matched;
                n_skid_ovf     = i_res.overflow;
            end else begin
                n_out_valid   = 1'b1;
                n_out_matched = i_res.matched;
                n_out_ovf     = i_res.overflow;
            end
        end else if (w_take) begin
            n_out_valid   = r_skid_valid;
            n_out_matched = r_skid_matched;
            n_out_ovf     = r_skid_ovf;
            n_skid_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_matched  <= n_out_matched;
        r_out_ovf      <= n_out_ovf;
        r_skid_matched <= n_skid_matched;
        r_skid_ovf     <= n_skid_ovf;
    end

    assign o_can_accept           = !r_skid_valid;
    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_out_matched;
    assign o_out.pattern_overflow = r_out_ovf;

endmodule

// ===== sv/glob_wildcard_matcher.sv =====
// Glob matcher for whole subjects with '*', '?' and backslash escapes.
// The input channel carries one beat per pattern character, subject
// character, end of subject or clear pattern command. The output channel
// carries one beat per end of subject with the match and overflow flags.
// Pattern characters are loaded first; subject characters then update all
// pattern positions in parallel through a row of cells, one per token.
// A new beat of any kind is taken each cycle while ready is high.
// The result of an end of subject beat is registered before it appears.
// The output has a register and a one-beat skid stage; the input drops
// ready only while both hold results that the receiver has not taken.
// Reset empties the pattern, clears the overflow flag and the pending
// escape, and leaves only position zero active. The pattern is kept across
// subjects until a clear pattern beat.
module glob_wildcard_matcher import gwm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gwm_in_if.sink    i_in,
    gwm_out_if.source o_out
);

    logic             w_accept;
    logic             w_can_accept;
    logic [LEN_W-1:0] w_len;
    logic             w_ovf;
    t_wr_ctrl         w_wr;
    t_cell_ctrl       w_ctrl;
    t_result          w_res;
    logic [MAX_PATTERN-1:0] w_close;
    logic [MAX_PATTERN-1:0] w_adv;
    logic [MAX_PATTERN-1:0] w_hit;
    logic             r_act_end;
    logic             n_act_end;
    logic             w_hit_end;

    assign i_in.ready = w_can_accept;
    assign w_accept   = i_in.valid & w_can_accept;

    gwm_loader u_loader (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_func     (i_in.func),
        .i_char     (i_in.char_value),
        .o_len      (w_len),
        .o_overflow (w_ovf),
        .o_wr       (w_wr)
    );

    assign w_ctrl.step  = w_accept && (i_in.func == FUNC_SUBJECT);
    assign w_ctrl.rearm = w_accept && ((i_in.func == FUNC_END) || (i_in.func == FUNC_CLEAR));
    assign w_ctrl.ch    = i_in.char_value;
    assign w_ctrl.len   = w_len;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_cell
        gwm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_index    (IDX_W'(g)),
            .i_ctrl     (w_ctrl),
            .i_wr       (w_wr),
            .i_close_in ((g == 0) ? 1'b0 : w_close[(g == 0) ? 0 : g - 1]),
            .i_adv_in   ((g == 0) ? 1'b0 : w_adv[(g == 0) ? 0 : g - 1]),
            .o_close    (w_close[g]),
            .o_adv      (w_adv[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign w_hit_end = (r_act_end | w_close[MAX_PATTERN-1]) &&
                       (w_len == LEN_W'(MAX_PATTERN));

    always_comb begin
        n_act_end = r_act_end;
        if (w_ctrl.rearm) begin
            n_act_end = 1'b0;
        end else if (w_ctrl.step) begin
            n_act_end = w_adv[MAX_PATTERN-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_end <= 1'b0;
        end else begin
            r_act_end <= n_act_end;
        end
    end

    assign w_res.valid    = w_accept && (i_in.func == FUNC_END);
    assign w_res.matched  = ((|w_hit) | w_hit_end) & !w_ovf;
    assign w_res.overflow = w_ovf;

    gwm_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_res        (w_res),
        .o_can_accept (w_can_accept),
        .o_out        (o_out)
    );

endmodule

// ===== sv/gwm_checker.sv =====
module gwm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_matched,
    input logic i_out_overflow
);

    // An overflowed pattern never reports a match.
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_overflow) |-> !i_out_matched)
        else $error("match reported with pattern overflow");

    // Input back-pressure only comes from results that are waiting.
    a_ready_low_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !i_in_ready) |-> i_out_valid)
        else $error("input stalled with no pending result");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_matched) && $stable(i_out_overflow)))
        else $error("stalled result beat changed");

    // No result is pending right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!i_out_valid && i_in_ready))
        else $error("result pending after reset");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_matched  (o_out.matched),
    .i_out_overflow (o_out.pattern_overflow)
);
